[hdl/vbad_pkg.sv]
// Shared constants and types of the voxel block average downsampler.
package vbad_pkg;

  // Default geometry and sample format.
  localparam int VBAD_OUT_SIDE        = 32;
  localparam int VBAD_MAX_BLOCK_SHIFT = 4;
  localparam int VBAD_SAMPLE_BITS     = 16;

  // Fixed field widths.
  localparam int CELL_W  = 5;
  localparam int SHIFT_W = 3;
  localparam int SH3_W   = 5;

  // Register port format.
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  // Word index of the block shift register.
  localparam logic REG_BLOCK_SHIFT = 1'b0;

  // Block shift after reset.
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;

  // Per-sample control information produced by the position tracker.
  typedef struct packed {
    logic              first;
    logic              last;
    logic              fin;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
  } pos_info_t;

endpackage

[hdl/vbad_pos.sv]
// Position tracker: raster position counters, accumulator index and block flags.
module vbad_pos
  import vbad_pkg::*;
#(
  parameter int OUT_SIDE        = VBAD_OUT_SIDE,
  parameter int MAX_BLOCK_SHIFT = VBAD_MAX_BLOCK_SHIFT,
  localparam int POS_W          = $clog2(OUT_SIDE) + MAX_BLOCK_SHIFT,
  localparam int IDX_W          = $clog2(OUT_SIDE * OUT_SIDE)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               clear,
  input  logic [SHIFT_W-1:0] shift,
  output logic [IDX_W-1:0]   idx,
  output pos_info_t          info
);

  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] pos_z;
  logic [POS_W-1:0] side_m1;
  logic [POS_W-1:0] lmask;
  logic [POS_W-1:0] cx;
  logic [POS_W-1:0] cy;
  logic [POS_W-1:0] cz;

  // Grid side and in-block mask for the current shift.
  assign side_m1 = POS_W'((OUT_SIDE << shift) - 1);
  assign lmask   = POS_W'((1 << shift) - 1);

  // Cell coordinates and the accumulator for this cell's y and z.
  assign cx  = pos_x >> shift;
  assign cy  = pos_y >> shift;
  assign cz  = pos_z >> shift;
  assign idx = IDX_W'(IDX_W'(cy) * IDX_W'(OUT_SIDE) + IDX_W'(cz));

  // Block boundary flags and the coordinates carried with the sample.
  always_comb begin
    info.first  = ((pos_x | pos_y | pos_z) & lmask) == '0;
    info.last   = ((pos_x & lmask) == lmask) && ((pos_y & lmask) == lmask) &&
                  ((pos_z & lmask) == lmask);
    info.fin    = (pos_x == side_m1) && (pos_y == side_m1) && (pos_z == side_m1);
    info.cell_x = CELL_W'(cx);
    info.cell_y = CELL_W'(cy);
    info.cell_z = CELL_W'(cz);
  end

  // Raster counters, z innermost, wrapping after the whole volume.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (advance) begin
      if (pos_z == side_m1) begin
        pos_z <= '0;
        if (pos_y == side_m1) begin
          pos_y <= '0;
          pos_x <= (pos_x == side_m1) ? '0 : pos_x + 1'b1;
        end else begin
          pos_y <= pos_y + 1'b1;
        end
      end else begin
        pos_z <= pos_z + 1'b1;
      end
    end
  end

endmodule

[hdl/voxel_block_average_downsample_unit.sv]
// Usage: 3-D average pooling of a voxel stream into cells of 2^shift per side.
// Samples enter on voxel_value/voxel_valid/voxel_stall in raster order, x
// outermost and z innermost; a transaction completes when valid is high and
// stall is low. The last sample of each cubic block yields one result
// transaction on block_mean, cell_x/y/z and final_cell; other samples yield
// none. A sample passes the update stage and the output register before its
// result appears. One sample can be taken every cycle unless the input stalls:
// the accumulator plane is a single-port-read, single-port-write memory with a
// registered read, and a back-to-back update of the same accumulator is served from a
// forwarding register. A held result does not block input; only a block's last sample
// waits while the previous result is still stalled, which then stalls the input.
// block_shift lies at byte address 0 of the register port; values above the
// maximum act as the maximum, and any write to it restarts the volume.
// Reset clears the position counters and sets block_shift to 2. The
// accumulators need no clearing: the first sample of each block overwrites its
// entry.
module voxel_block_average_downsample_unit
  import vbad_pkg::*;
#(
  parameter int OUT_SIDE        = VBAD_OUT_SIDE,
  parameter int MAX_BLOCK_SHIFT = VBAD_MAX_BLOCK_SHIFT,
  parameter int SAMPLE_BITS     = VBAD_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready,
  input  logic                          voxel_valid,
  output logic                          voxel_stall,
  input  logic signed [SAMPLE_BITS-1:0] voxel_value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] block_mean,
  output logic [CELL_W-1:0]             cell_x,
  output logic [CELL_W-1:0]             cell_y,
  output logic [CELL_W-1:0]             cell_z,
  output logic                          final_cell
);

  localparam int IDX_W = $clog2(OUT_SIDE * OUT_SIDE);
  localparam int DEPTH = OUT_SIDE * OUT_SIDE;
  localparam int ACC_W = SAMPLE_BITS + 3 * MAX_BLOCK_SHIFT;

  logic [SHIFT_W-1:0]             block_shift;
  logic [SHIFT_W-1:0]             eff_shift;
  logic [SH3_W-1:0]               sh3;
  logic                           shift_wr;
  logic                           accept;
  logic [IDX_W-1:0]               pos_idx;
  pos_info_t                      pos_info;

  logic                           s1_valid;
  logic                           s1_hold;
  logic                           s1_adv;
  pos_info_t                      s1_info;
  logic [IDX_W-1:0]               s1_idx;
  logic signed [SAMPLE_BITS-1:0]  s1_sample;
  logic signed [ACC_W-1:0]        s1_base;
  logic signed [ACC_W-1:0]        s1_sum;
  logic signed [ACC_W-1:0]        s1_mean;

  logic signed [ACC_W-1:0]        sum_mem [DEPTH];
  logic signed [ACC_W-1:0]        rd_data;
  logic                           fwd_valid;
  logic [IDX_W-1:0]               fwd_idx;
  logic signed [ACC_W-1:0]        fwd_data;

  // Register port: one writable register, no wait states.
  assign pready   = 1'b1;
  assign shift_wr = psel && penable && pwrite && (paddr[2] == REG_BLOCK_SHIFT);
  assign prdata   = (paddr[2] == REG_BLOCK_SHIFT) ? APB_DATA_W'(block_shift) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_shift <= SHIFT_RESET;
    end else if (shift_wr) begin
      block_shift <= pwdata[SHIFT_W-1:0];
    end
  end

  // Shift saturated to the supported maximum, and the mean's shift of three times it.
  assign eff_shift = (block_shift > SHIFT_W'(MAX_BLOCK_SHIFT)) ? SHIFT_W'(MAX_BLOCK_SHIFT)
                                                               : block_shift;
  assign sh3 = SH3_W'({eff_shift, 1'b0}) + SH3_W'(eff_shift);

  // Input handshake: stall only while a finishing sample waits for the output.
  assign s1_hold     = s1_info.last && result_valid && result_stall;
  assign s1_adv      = s1_valid && !s1_hold;
  assign voxel_stall = s1_valid && s1_hold;
  assign accept      = voxel_valid && !voxel_stall;

  vbad_pos #(
    .OUT_SIDE        (OUT_SIDE),
    .MAX_BLOCK_SHIFT (MAX_BLOCK_SHIFT)
  ) u_pos (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .clear   (shift_wr),
    .shift   (eff_shift),
    .idx     (pos_idx),
    .info    (pos_info)
  );

  // Accumulator plane: read on acceptance, written back from the update stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= sum_mem[pos_idx];
    end
    if (s1_adv) begin
      sum_mem[s1_idx] <= s1_sum;
    end
  end

  // Most recent write, covering a read that raced with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_adv) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fwd_idx  <= s1_idx;
      fwd_data <= s1_sum;
    end
  end

  // Update stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info   <= pos_info;
      s1_idx    <= pos_idx;
      s1_sample <= voxel_value;
    end
  end

  // Accumulate: the first sample of a block starts from zero.
  always_comb begin
    if (s1_info.first) begin
      s1_base = '0;
    end else if (fwd_valid && (fwd_idx == s1_idx)) begin
      s1_base = fwd_data;
    end else begin
      s1_base = rd_data;
    end
    s1_sum  = s1_base + ACC_W'(s1_sample);
    s1_mean = s1_sum >>> sh3;
  end

  // Output register, loaded by a block's last sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_info.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_info.last) begin
      block_mean <= s1_mean[SAMPLE_BITS-1:0];
      cell_x     <= s1_info.cell_x;
      cell_y     <= s1_info.cell_y;
      cell_z     <= s1_info.cell_z;
      final_cell <= s1_info.fin;
    end
  end

`ifndef SYNTHESIS
  // A finishing sample leaving the update stage always presents a result.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_info.last) |=> result_valid)
    else $error("finishing sample did not produce a result");

  // A sample that both opens and closes a block needs a block side of one.
  a_single_sample_block: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_info.first && s1_info.last) |-> (eff_shift == '0))
    else $error("block opened and closed by one sample with a nonzero shift");

  // The forwarding register tracks the accumulator just written.
  a_forward_tracks_write: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (fwd_valid && (fwd_idx == $past(s1_idx)) && (fwd_data == $past(s1_sum))))
    else $error("forwarding register lost the last write");
`endif

endmodule
